// ===== hdl/bbd_pkg.sv =====
// bbd_pkg: shared types, constants and pixel math for the bayer demosaic
// no dependencies
`timescale 1ns / 1ps
package bbd_pkg;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam logic [1:0]  RST_LAYOUT = 2'd0;
  localparam logic [11:0] RST_WIDTH = 12'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;

  localparam logic [1:0] REG_LAYOUT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [1:0] COL_R = 2'd0;
  localparam logic [1:0] COL_G = 2'd1;
  localparam logic [1:0] COL_B = 2'd2;

  // 3x3 neighborhood, [row][col], col 0 = left of pixel
  typedef logic [2:0][2:0][7:0] nbhd_t;

  // one pixel job handed to the color unit
  typedef struct packed {
    nbhd_t       win;
    logic [1:0]  layout;
    logic        y_odd;
    logic        x_odd;
    logic        top;
    logic        bot;
    logic        lft;
    logic        rgt;
    logic        run_last;
    logic        frame_end;
  } pix_job_t;

  function automatic logic [1:0] colour_at(input logic [1:0] lay, input logic yo,
                                           input logic xo);
    logic [1:0] c;
    unique case ({lay, yo, xo})
      4'b0000: c = COL_R; 4'b0001: c = COL_G; 4'b0010: c = COL_G; 4'b0011: c = COL_B;
      4'b0100: c = COL_G; 4'b0101: c = COL_B; 4'b0110: c = COL_R; 4'b0111: c = COL_G;
      4'b1000: c = COL_G; 4'b1001: c = COL_R; 4'b1010: c = COL_B; 4'b1011: c = COL_G;
      4'b1100: c = COL_B; 4'b1101: c = COL_G; 4'b1110: c = COL_G; default: c = COL_R;
    endcase
    return c;
  endfunction
endpackage

// ===== hdl/bbd_ram.sv =====
// bbd_ram: generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
module bbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== hdl/bbd_colour.sv =====
// bbd_colour: bilinear interpolation and luma for one pixel, two register stages
// depends on bbd_pkg
`timescale 1ns / 1ps
module bbd_colour (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  bbd_pkg::pix_job_t job,
  output logic              out_vld,
  output logic [33:0]       out_data
);
  import bbd_pkg::*;

  logic [2:0][7:0] val;
  logic [2:0][7:0] val_r;
  logic s1_vld_r, s2_vld_r;
  logic s1_last_r, s1_fend_r;
  logic [33:0] out_data_r;

  always_comb begin
    logic [1:0]  own, cc;
    logic [10:0] sum;
    logic [3:0]  cnt;
    logic [7:0]  q;
    logic        ok;
    own = colour_at(job.layout, job.y_odd, job.x_odd);
    for (int ch = 0; ch < 3; ch++) begin
      sum = '0;
      cnt = '0;
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ok = !(dy == 1 && dx == 1);
          if (dy == 0 && job.top) ok = 1'b0;
          if (dy == 2 && job.bot) ok = 1'b0;
          if (dx == 0 && job.lft) ok = 1'b0;
          if (dx == 2 && job.rgt) ok = 1'b0;
          cc = colour_at(job.layout, job.y_odd ^ (dy != 1), job.x_odd ^ (dx != 1));
          if (ok && cc == 2'(ch)) begin
            sum = sum + 11'(job.win[dy][dx]);
            cnt = cnt + 4'd1;
          end
        end
      end
      // counts are 1, 2, 3 or 4 for legal sizes
      unique case (cnt)
        4'd1: q = sum[7:0];
        4'd2: q = sum[8:1];
        4'd3: q = 8'((20'(sum) * 20'd683) >> 11);
        4'd4: q = sum[9:2];
        default: q = '0;
      endcase
      val[ch] = (own == 2'(ch)) ? job.win[1][1] : q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val;
      s1_last_r <= job.run_last;
      s1_fend_r <= job.frame_end;
      out_data_r <= {s1_fend_r, s1_last_r,
                     8'((17'(val_r[0]) * 17'd77 + 17'(val_r[1]) * 17'd150
                         + 17'(val_r[2]) * 17'd29) >> 8),
                     val_r[2], val_r[1], val_r[0]};
    end
  end
  assign out_vld = s2_vld_r;
  assign out_data = out_data_r;
endmodule

// ===== hdl/bayer_bilinear_demosaic.sv =====
// bayer_bilinear_demosaic: top level, line stores, window and result queue
// depends on bbd_pkg, bbd_ram, bbd_colour
`timescale 1ns / 1ps
// usage:
//   in_*  : raw 8-bit samples in raster order, one per transaction
//   cfg_* : register writes (0 layout, 1 frame width, 2 frame height); write
//           only while idle
//   out_* : one transaction per pixel: red, green, blue, luma plus run_last
//           (last result caused by an input) and frame_end flags
// pixel (y,x) appears after sample (y+1,x+1) arrives, one row of lag; on the
// last row each pixel follows the one above it, so one input may cause up to
// four results (at the last column of the last row)
// throughput: one sample per cycle while results are one per input and the output
// takes them; input stalls while an input's extra results drain, one result per cycle
// a sample's first result passes the line store read, the job queue, the two color
// unit stages and the output queue before it is offered
// the two line stores are 8-bit rams with registered read; a new sample is written
// over the same column in the cycle after its read
// reset clears counters, window and queues; line store contents are never
// read before they are written inside the frame
// output stall: an eight-entry queue absorbs in-flight results; the input is
// held off whenever the queue cannot take all results still in flight
module bayer_bilinear_demosaic #(
  parameter int MAX_WIDTH = bbd_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // raw_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red, green, blue, luma
  output logic        out_tlast,  // run_last
  output logic        out_tuser,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import bbd_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CAP = MAX_WIDTH & ~1;

  logic [1:0]  layout_r;
  logic [11:0] fw_r;
  logic [12:0] fh_r;
  logic [13:0] w_eff, h_eff;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= RST_LAYOUT;
      fw_r <= RST_WIDTH;
      fh_r <= RST_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LAYOUT: layout_r <= cfg_data[1:0];
        REG_WIDTH:  fw_r <= cfg_data[11:0];
        REG_HEIGHT: fh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = 14'({fw_r[11:1], 1'b0});
    if (w_eff > 14'(CAP)) w_eff = 14'(CAP);
    if (w_eff < 14'd4) w_eff = 14'd4;
    h_eff = 14'({fh_r[12:1], 1'b0});
    if (h_eff > 14'd4096) h_eff = 14'd4096;
    if (h_eff < 14'd2) h_eff = 14'd2;
  end

  // stage A: accept, count, read line stores
  logic [13:0] col_r, row_r, c_now, r_now;
  logic        acc;
  logic        a_vld_r;
  logic [13:0] a_col_r, a_row_r;
  logic [7:0]  a_smp_r;
  logic [7:0]  above_q, cur_q;
  logic        en;

  always_comb begin
    c_now = col_r;
    r_now = row_r;
    if (col_r >= w_eff || row_r >= h_eff) begin
      c_now = '0;
      r_now = '0;
    end
  end

  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      if (c_now + 14'd1 >= w_eff) begin
        col_r <= '0;
        row_r <= (r_now + 14'd1 >= h_eff) ? 14'd0 : r_now + 14'd1;
      end else begin
        col_r <= c_now + 14'd1;
        row_r <= r_now;
      end
    end
  end

  bbd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_above (
    .clk(clk), .we(a_vld_r), .waddr(a_col_r[AW-1:0]), .wdata(cur_q),
    .re(acc), .raddr(c_now[AW-1:0]), .rdata(above_q));
  bbd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_cur (
    .clk(clk), .we(a_vld_r), .waddr(a_col_r[AW-1:0]), .wdata(a_smp_r),
    .re(acc), .raddr(c_now[AW-1:0]), .rdata(cur_q));

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else a_vld_r <= acc;
  end
  always_ff @(posedge clk) begin
    if (acc) begin
      a_col_r <= c_now;
      a_row_r <= r_now;
      a_smp_r <= in_tdata;
    end
  end

  // stage B: window shift and job generation; back-to-back same column is
  // impossible since width is at least four, so no forwarding is needed
  logic [2:0][3:0][7:0] win_r;
  logic [2:0][3:0][7:0] win_n;
  logic [3:0]           jv;
  pix_job_t             jobs [4];
  logic [2:0]           njob;

  always_comb begin
    logic lastrow, lastcol;
    pix_job_t j;
    int ry, rx;
    win_n = win_r;
    for (int y = 0; y < 3; y++) begin
      win_n[y][3] = win_r[y][2];
      win_n[y][2] = win_r[y][1];
      win_n[y][1] = win_r[y][0];
    end
    win_n[0][0] = above_q;
    win_n[1][0] = cur_q;
    win_n[2][0] = a_smp_r;
    lastrow = (a_row_r == h_eff - 14'd1);
    lastcol = (a_col_r == w_eff - 14'd1);
    jv = '0;
    for (int k = 0; k < 4; k++) begin
      j = '0;
      j.layout = layout_r;
      // k0 (r-1,c-1) k1 (r,c-1) k2 (r-1,c) k3 (r,c); wx=1 for k0/k1
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          ry = dy + ((k == 1 || k == 3) ? 1 : 0);
          rx = 2 - dx - ((k >= 2) ? 1 : 0);
          // taps below the last row or right of the last column stay zero
          if (ry <= 2 && rx >= 0) j.win[dy][dx] = win_n[ry[1:0]][rx[1:0]];
        end
      end
      j.y_odd = (k == 1 || k == 3) ? a_row_r[0] : ~a_row_r[0];
      j.x_odd = (k < 2) ? ~a_col_r[0] : a_col_r[0];
      j.top = (k == 1 || k == 3) ? 1'b0 : (a_row_r == 14'd1);
      if (k == 0 || k == 2) j.top = (a_row_r == 14'd1);
      j.bot = (k == 1 || k == 3);
      j.lft = (k < 2) ? (a_col_r == 14'd1) : 1'b0;
      j.rgt = (k >= 2);
      j.frame_end = (k == 3);
      jobs[k] = j;
    end
    if (a_vld_r && a_row_r >= 14'd1) begin
      if (a_col_r >= 14'd1) begin
        jv[0] = 1'b1;
        jv[1] = lastrow;
      end
      if (lastcol) begin
        jv[2] = 1'b1;
        jv[3] = lastrow;
      end
    end
    njob = 3'($countones(jv));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= '0;
    else if (a_vld_r) win_r <= win_n;
  end

  // job queue, 8 deep, feeds the color unit one job per cycle
  logic [$bits(pix_job_t)-1:0] jq_r [8];
  logic [2:0] jh_r, jt_r;
  logic [3:0] jc_r;
  logic       jpop;
  logic [3:0] jc_nxt;
  pix_job_t   jhead;

  // results in flight: job queue + color pipe (2) + output queue must fit
  logic [1:0] cp_cnt;
  logic [3:0] oq_cnt_r;
  logic       c_vld;
  logic [33:0] c_data;
  logic [3:0] inflight;

  assign jhead = pix_job_t'(jq_r[jh_r]);
  assign jpop = (jc_r != 4'd0);
  assign en = 1'b1;

  always_ff @(posedge clk) begin
    logic [2:0] t;
    logic [2:0] last_k;
    if (!rst_n) begin
      jh_r <= '0;
      jt_r <= '0;
      jc_r <= '0;
    end else begin
      t = jt_r;
      last_k = 3'd0;
      for (int k = 0; k < 4; k++) if (jv[k]) last_k = 3'(k);
      for (int k = 0; k < 4; k++) begin
        if (jv[k]) begin
          jq_r[t] <= {jobs[k][$bits(pix_job_t)-1:2], (3'(k) == last_k),
                      jobs[k].frame_end && (a_row_r == h_eff - 14'd1)
                      && (a_col_r == w_eff - 14'd1)};
          t = t + 3'd1;
        end
      end
      jt_r <= t;
      if (jpop) jh_r <= jh_r + 3'd1;
      jc_r <= jc_nxt;
    end
  end
  assign jc_nxt = jc_r + 4'(njob) - 4'(jpop);

  bbd_colour u_colour (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(jpop), .job(jhead),
    .out_vld(c_vld), .out_data(c_data));

  // output queue, 8 deep
  logic [33:0] oq_r [8];
  logic [2:0]  oh_r, ot_r;
  logic        opop;
  logic        p1_r, p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else begin
      p1_r <= jpop;
      p2_r <= p1_r;
    end
  end
  assign cp_cnt = 2'(p1_r) + 2'(p2_r);

  assign opop = out_tvalid && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oh_r <= '0;
      ot_r <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (c_vld) begin
        oq_r[ot_r] <= c_data;
        ot_r <= ot_r + 3'd1;
      end
      if (opop) oh_r <= oh_r + 3'd1;
      oq_cnt_r <= oq_cnt_r + 4'(c_vld) - 4'(opop);
    end
  end

  // results the offered sample would add, known from its position
  logic [2:0] k_new;
  logic [4:0] need;
  always_comb begin
    logic lr;
    lr = (r_now == h_eff - 14'd1);
    k_new = 3'd0;
    if (r_now >= 14'd1) begin
      if (c_now >= 14'd1) k_new = k_new + (lr ? 3'd2 : 3'd1);
      if (c_now == w_eff - 14'd1) k_new = k_new + (lr ? 3'd2 : 3'd1);
    end
  end

  // results in flight, those of the stage B item and those of the offered
  // sample must all fit the output queue
  assign inflight = jc_r + 4'(cp_cnt) + oq_cnt_r;
  assign need = 5'(inflight) + 5'(njob) + 5'(k_new);
  assign in_tready = (need <= 5'd8);

  assign out_tvalid = (oq_cnt_r != 4'd0);
  assign out_tdata = oq_r[oh_r][31:0];
  assign out_tlast = oq_r[oh_r][32];
  assign out_tuser = oq_r[oh_r][33];
endmodule

// ===== tb/tb_bayer_bilinear_demosaic.sv =====
// tb_bayer_bilinear_demosaic: self-checking bench for the bayer demosaic, own predictor
// drives raw frames over several layouts and sizes with random idling; depends on bbd_pkg, bayer_bilinear_demosaic
`timescale 1ns / 1ps
module tb_bayer_bilinear_demosaic;
  import bbd_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] luma;
    logic       run_last;
    logic       frame_end;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  bayer_bilinear_demosaic dut (.*);

  // predictor state, a mirror of the block
  logic [7:0]  rows_above [2048];
  logic [7:0]  rows_cur [2048];
  logic [7:0]  win [3][4];
  int          col_pos;
  int          row_pos;
  logic [1:0]  m_layout;
  logic [11:0] m_width;
  logic [12:0] m_height;

  logic [7:0]  raw_q [$];     // samples waiting for the sender
  pixel_t      pixel_q [$];   // predicted pixels not yet seen
  logic        in_taken;
  int          fails;
  int          pix_seen;
  int          hold_left;
  bit          hold_done;
  bit          no_idle;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mosaic color of a site, per layout
  function automatic logic [1:0] site_colour(int y, int x);
    logic [1:0] tbl [4][4];
    tbl[0] = '{COL_R, COL_G, COL_G, COL_B};
    tbl[1] = '{COL_G, COL_B, COL_R, COL_G};
    tbl[2] = '{COL_G, COL_R, COL_B, COL_G};
    tbl[3] = '{COL_B, COL_G, COL_G, COL_R};
    return tbl[m_layout][((y & 1) << 1) | (x & 1)];
  endfunction

  function automatic int eff_w();
    int v;
    v = m_width & 12'hffe;
    if (v > 2048) v = 2048;
    if (v < 4) v = 4;
    return v;
  endfunction

  function automatic int eff_h();
    int v;
    v = m_height & 13'h1ffe;
    if (v > 4096) v = 4096;
    if (v < 2) v = 2;
    return v;
  endfunction

  // interpolate one pixel whose own sample sits at window (wy, wx)
  function automatic void predict_pixel(int py, int px, int wy, int wx, int w, int h);
    int     chv [3];
    int     sum, cnt, ny, nx, ry, rx;
    pixel_t p;
    for (int ch = 0; ch < 3; ch++) begin
      if (ch == site_colour(py, px)) begin
        chv[ch] = int'(win[wy][wx]);
      end else begin
        sum = 0;
        cnt = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) begin
            ny = py + dy;
            nx = px + dx;
            ry = wy + dy;
            rx = wx - dx;  // window column 0 is the newest sample
            if ((dy != 0 || dx != 0) && ny >= 0 && nx >= 0 && ny < h && nx < w &&
                ry >= 0 && ry <= 2 && rx >= 0 && rx <= 3 && site_colour(ny, nx) == ch) begin
              sum += int'(win[ry][rx]);
              cnt++;
            end
          end
        chv[ch] = cnt ? sum / cnt : 0;
      end
    end
    p.red       = 8'(chv[0]);
    p.green     = 8'(chv[1]);
    p.blue      = 8'(chv[2]);
    p.luma      = 8'((77 * chv[0] + 150 * chv[1] + 29 * chv[2]) >> 8);
    p.run_last  = 0;
    p.frame_end = (py == h - 1 && px == w - 1);
    pixel_q.push_back(p);
  endfunction

  function automatic void predict_sample(logic [7:0] s);
    int w, h, c, r, n;
    w = eff_w();
    h = eff_h();
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    for (int y = 0; y < 3; y++)
      for (int x = 3; x > 0; x--) win[y][x] = win[y][x-1];
    win[0][0] = rows_above[c];
    win[1][0] = rows_cur[c];
    win[2][0] = s;
    rows_above[c] = rows_cur[c];
    rows_cur[c] = s;
    n = pixel_q.size();
    if (r >= 1 && c >= 1) begin
      predict_pixel(r - 1, c - 1, 1, 1, w, h);
      if (r == h - 1) predict_pixel(r, c - 1, 2, 1, w, h);
    end
    if (r >= 1 && c == w - 1) begin
      predict_pixel(r - 1, c, 1, 0, w, h);
      if (r == h - 1) predict_pixel(r, c, 2, 0, w, h);
    end
    if (pixel_q.size() > n) pixel_q[pixel_q.size() - 1].run_last = 1;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end
  endfunction

  // both sides idle only while the no-idle stretch is off
  function automatic bit quiet();
    return no_idle;
  endfunction

  // predictor and register mirror, fed by accepted transactions
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_sample(in_tdata);
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LAYOUT: m_layout = cfg_data[1:0];
        REG_WIDTH:  m_width  = cfg_data[11:0];
        REG_HEIGHT: m_height = cfg_data;
        default: ;
      endcase
    end
  end

  // sender: next sample at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rst_n && raw_q.size() > 0 && (quiet() || $urandom_range(0, 99) >= 7)) begin
        in_tdata  <= raw_q.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the block backs up
  always @(negedge clk) begin
    if (!hold_done && pix_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet() || $urandom_range(0, 99) >= 7;
    end
  end

  // monitor: each result transaction against the oldest prediction
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      pix_seen <= pix_seen + 1;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel: tdata %h", out_tdata);
        fails++;
      end else begin
        e = pixel_q.pop_front();
        if (out_tdata[7:0] !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, out_tdata[7:0]);
          fails++;
        end
        if (out_tdata[15:8] !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, out_tdata[15:8]);
          fails++;
        end
        if (out_tdata[23:16] !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, out_tdata[23:16]);
          fails++;
        end
        if (out_tdata[31:24] !== e.luma) begin
          $error("luma: expected %0d, got %0d", e.luma, out_tdata[31:24]);
          fails++;
        end
        if (out_tlast !== e.run_last) begin
          $error("run_last: expected %0b, got %0b", e.run_last, out_tlast);
          fails++;
        end
        if (out_tuser !== e.frame_end) begin
          $error("frame_end: expected %0b, got %0b", e.frame_end, out_tuser);
          fails++;
        end
      end
    end
  end

  // wait until all samples are sent and all predicted pixels seen, then idle so any stray pixel is caught
  task automatic drain();
    while (raw_q.size() > 0 || in_tvalid || pixel_q.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic [1:0] lay, logic [12:0] w, logic [12:0] h);
    drain();
    write_reg(REG_LAYOUT, 13'(lay));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // queue n samples; pattern 0 random, 1 every third sample 0xff and the rest zero, 2 all ones
  task automatic queue_samples(int n, int pattern);
    for (int i = 0; i < n; i++)
      case (pattern)
        1: raw_q.push_back((i % 3 == 0) ? 8'hff : 8'h00);
        2: raw_q.push_back(8'hff);
        default: raw_q.push_back(8'($urandom_range(0, 255)));
      endcase
  endtask

  initial begin
    int w, h;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_index = REG_LAYOUT;
    cfg_data = 0;
    fails = 0;
    pix_seen = 0;
    hold_left = 0;
    hold_done = 0;
    no_idle = 0;
    in_taken = 0;
    col_pos = 0;
    row_pos = 0;
    m_layout = RST_LAYOUT;
    m_width = RST_WIDTH;
    m_height = RST_HEIGHT;
    for (int i = 0; i < 2048; i++) begin
      rows_above[i] = 0;
      rows_cur[i] = 0;
    end
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++) win[y][x] = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: smallest frame, extreme samples, corner-only neighborhoods
    setup(2'd0, 13'd4, 13'd2);
    queue_samples(8, 1);
    setup(2'd3, 13'd4, 13'd2);
    queue_samples(8, 2);
    // odd sizes round down, tiny ones clamp up
    setup(2'd1, 13'd5, 13'd1);
    queue_samples(8, 0);
    // a taller frame; the long receiver hold-off lands inside it
    setup(2'd1, 13'd10, 13'd6);
    queue_samples(60, 0);

    // random frames of small sizes over random layouts, the first ones without idling
    for (int f = 0; f < 4; f++) begin
      w = 2 * $urandom_range(2, 5);
      h = 2 * $urandom_range(1, 3);
      setup(2'($urandom_range(0, 3)), 13'(w + $urandom_range(0, 1)),
            13'(h + $urandom_range(0, 1)));
      no_idle = (f < 3);
      queue_samples(w * h, 0);
    end

    // oversize width that clamps, frame cut short
    setup(2'd1, 13'd4095, 13'd3);
    queue_samples(12, 0);
    // clamped height on the narrowest width, cut short
    setup(2'd3, 13'd3, 13'd8191);
    queue_samples(12, 0);
    // back to a small frame after a partial one
    setup(2'd2, 13'd6, 13'd2);
    queue_samples(12, 0);

    drain();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
